// ===== src/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: shared package
// Constants, lookup functions and typedefs for day and second counts.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned MicroPerSec = 1000000;
    localparam int unsigned EpochYear   = 1970;
    localparam int unsigned DaysCommon  = 365;
    localparam int unsigned DaysLeap    = 366;

    // Day count since the epoch fits 16 bits (at most 49710).
    typedef logic [15:0] days_t;
    typedef logic [16:0] secs_day_t;

    // Days from the epoch to 1 January of the year 1970 + idx.
    function automatic logic [15:0] year_start(input logic [7:0] idx);
        logic [15:0] acc;
        logic [11:0] y;
        acc = '0;
        for (int i = 0; i < 256; i++) begin
            if (i < int'(idx)) begin
                y = 12'(EpochYear + i);
                acc = acc + ((y[1:0] == 2'd0 && y != 12'd2100) ? 16'(DaysLeap)
                                                                : 16'(DaysCommon));
            end
        end
        return acc;
    endfunction

    // Days before the first of month m (0 based), common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:  r = 9'd0;
            4'd1:  r = 9'd31;
            4'd2:  r = 9'd59;
            4'd3:  r = 9'd90;
            4'd4:  r = 9'd120;
            4'd5:  r = 9'd151;
            4'd6:  r = 9'd181;
            4'd7:  r = 9'd212;
            4'd8:  r = 9'd243;
            4'd9:  r = 9'd273;
            4'd10: r = 9'd304;
            4'd11: r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'd0) && (y != 12'd2100);
    endfunction

endpackage

// ===== src/esc_stage.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: pipeline register stage
// One valid/stall register slice used between compute stages.
// ----------------------------------------------------------------------------
module esc_stage #(
    parameter int Width = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [Width-1:0] in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [Width-1:0] out_data
);
    logic             valid_reg;
    logic [Width-1:0] data_reg;

    // The slice loads whenever it is empty or its beat is leaving.
    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= in_data;
        end
    end
endmodule

// ===== src/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: top level
// Converts a 32-bit epoch second count into Gregorian date and time fields.
// ----------------------------------------------------------------------------
// Usage: present seconds_count with in_valid; the beat is taken on an edge
// where in_stall is low. Results leave on out_valid and are taken on an edge
// where out_stall is low. One beat in, one beat out, in order.
// The pipeline has four register slices: day split (multiply by a reciprocal),
// correction, year search and hour split, month search with minute split and
// field assembly. The microsecond product is built in two halves over the
// first two slices. Throughput is one beat per cycle while out_stall is low;
// the number of slices sets the latency.
// Reset empties every slice; no beat is presented after reset until a new
// input arrives. On a receiver stall a full slice holds its beat while all
// later slices are full; stall ripples back to in_stall, none lost or repeated.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seconds_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [51:0] micro_stamp
);
    import esc_pkg::*;

    // Stage 1: estimated day count via reciprocal, low microsecond product.
    localparam int W1 = 32 + 17 + 46;
    logic [W1-1:0] s1_d, s1_q;
    logic          v1, st1;
    logic [47:0]   recip_prod;
    logic [16:0]   day_est;
    always_comb
    begin
        // floor(x/86400) approx: x * 1628906023 >> 47, never above the quotient
        // and at most one below it.
        recip_prod = 48'((64'(seconds_count) * 64'd1628906023) >> 16);
        day_est    = 17'(recip_prod >> 31);
        s1_d = {seconds_count, day_est, 46'(64'(seconds_count[15:0]) * 64'(MicroPerSec))};
    end
    esc_stage #(.Width(W1)) u_s1 (.clk, .rst_n, .in_valid, .in_stall,
        .in_data(s1_d), .out_valid(v1), .out_stall(st1), .out_data(s1_q));

    // Stage 2: correct day count, remainder; high product added.
    localparam int W2 = 16 + 17 + 52;
    logic [W2-1:0] s2_d, s2_q;
    logic          v2, st2;
    logic [31:0]   secs1;
    logic [16:0]   d1;
    logic [47:0]   rem_wide;
    logic [51:0]   micro;
    always_comb
    begin
        secs1    = s1_q[W1-1 -: 32];
        d1       = s1_q[62:46];
        rem_wide = 48'(secs1) - 48'(d1) * 48'(SecsPerDay);
        if (rem_wide >= 48'(SecsPerDay))
        begin
            d1       = d1 + 17'd1;
            rem_wide = rem_wide - 48'(SecsPerDay);
        end
        micro = 52'(s1_q[45:0]) + (52'(64'(secs1[31:16]) * 64'(MicroPerSec)) << 16);
        s2_d  = {d1[15:0], rem_wide[16:0], micro};
    end
    esc_stage #(.Width(W2)) u_s2 (.clk, .rst_n, .in_valid(v1), .in_stall(st1),
        .in_data(s2_d), .out_valid(v2), .out_stall(st2), .out_data(s2_q));

    // Stage 3: year from day count, hour from seconds of day.
    localparam int W3 = 8 + 9 + 5 + 12 + 52;
    logic [W3-1:0] s3_d, s3_q;
    logic          v3, st3;
    logic [15:0]   days2;
    logic [16:0]   rem2;
    logic [7:0]    yidx;
    logic [15:0]   ystart;
    logic [4:0]    hr;
    logic [11:0]   rem_h;
    always_comb
    begin
        days2  = s2_q[W2-1 -: 16];
        rem2   = s2_q[68:52];
        yidx   = 8'd0;
        ystart = 16'd0;
        for (int i = 1; i < 137; i++)
        begin
            if (days2 >= year_start(8'(i)))
            begin
                yidx   = 8'(i);
                ystart = year_start(8'(i));
            end
        end
        // Hour by reciprocal: x * 74566 >> 28 is exact for x below 86400.
        hr    = 5'((34'(rem2) * 34'd74566) >> 28);
        rem_h = 12'(rem2 - 17'(hr) * 17'(SecsPerHour));
        s3_d  = {yidx, 9'(days2 - ystart), hr, rem_h, s2_q[51:0]};
    end
    esc_stage #(.Width(W3)) u_s3 (.clk, .rst_n, .in_valid(v2), .in_stall(st2),
        .in_data(s3_d), .out_valid(v3), .out_stall(st3), .out_data(s3_q));

    // Stage 4: month and day from day of year, minute and second.
    localparam int W4 = 12 + 4 + 5 + 5 + 6 + 6 + 52;
    logic [W4-1:0] s4_d, s4_q;
    logic          v4;
    logic [11:0]   yr;
    logic [8:0]    doy;
    logic [3:0]    mo;
    logic [8:0]    mstart;
    logic [11:0]   rm;
    logic [5:0]    mn;
    always_comb
    begin
        yr  = 12'(EpochYear) + 12'(s3_q[W3-1 -: 8]);
        doy = s3_q[W3-9 -: 9];
        mo  = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (doy >= month_start(4'(m)) + ((m >= 2 && is_leap(yr)) ? 9'd1 : 9'd0))
            begin
                mo = 4'(m);
            end
        end
        mstart = month_start(mo) + ((mo >= 4'd2 && is_leap(yr)) ? 9'd1 : 9'd0);
        rm = s3_q[63:52];
        // Minute by reciprocal: x * 4370 >> 18 is exact for x below 3600.
        mn = 6'((24'(rm) * 24'd4370) >> 18);
        s4_d = {yr, mo + 4'd1, 5'(doy - mstart + 9'd1), s3_q[68:64], mn,
                6'(rm - 12'(mn) * 12'(SecsPerMin)), s3_q[51:0]};
    end
    esc_stage #(.Width(W4)) u_s4 (.clk, .rst_n, .in_valid(v3), .in_stall(st3),
        .in_data(s4_d), .out_valid(v4), .out_stall(out_stall), .out_data(s4_q));

    assign out_valid = v4;
    assign {year, month, day, hour, minute, second, micro_stamp} = s4_q;
endmodule

// ===== src/esc_checker.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module esc_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [51:0] micro_stamp
);
    // A stalled result beat stays presented.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(micro_stamp))
        else $error("result beat dropped under stall");

    // Fields of a presented beat are in range.
    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month >= 4'd1 && month <= 4'd12 && day != 5'd0)
        else $error("month or day out of range");

    a_hour: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23)
        else $error("hour out of range");
endmodule

bind epoch_seconds_to_calendar esc_assertions u_esc_checker (.*);
